@@ src/rgb_pwm_with_smooth_fade_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_pwm_with_smooth_fade_assert.svh
// Assertion macros for the checker of the LED PWM fader.
// ----------------------------------------------------------------------------
`ifndef RGB_PWM_WITH_SMOOTH_FADE_ASSERT_SVH
`define RGB_PWM_WITH_SMOOTH_FADE_ASSERT_SVH

// same-cycle implication
`define RPWM_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbpwm check failed");

// next-cycle implication
`define RPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbpwm check failed");

// delayed implication
`define RPWM_ASSERT_D2(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("rgbpwm check failed");

`endif

@@ src/rgbpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpwm_pkg
// Types and constants of the twelve-channel LED PWM fader.
// ----------------------------------------------------------------------------
package rgbpwm_pkg;

    // four LEDs, three colors each
    localparam int NumLeds     = 4;
    localparam int NumColors   = 3;
    localparam int NumChannels = NumLeds * NumColors;

    localparam int LevelWidth  = 8;
    localparam int CfgIdxWidth = 8;
    localparam int CfgDataWidth = 8;

    // reset value of the PWM period register
    localparam logic [LevelWidth-1:0] PeriodReset = 8'd64;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_PWM_PERIOD = 8'd0;
    localparam logic [CfgIdxWidth-1:0] REG_FADE_DELAY = 8'd1;

    // color code with no channel behind it
    localparam logic [1:0] COLOR_UNUSED = 2'd3;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_command;

endpackage

@@ src/rgb_pwm_with_smooth_fade.sv @@
// A tick word passes through the input register and then the output register.
// One word per cycle while the output side does not stall; the input register and the output register
// keep the path short, and the fade update of all twelve channels runs in parallel.
// A set word gives no output word and never waits for the output side.
// Reset (synchronous, active low) clears all levels, counters and the pending
// flag, and loads the period register with 64 and the fade delay with 0.
// ----------------------------------------------------------------------------
// rgb_pwm_with_smooth_fade
// Twelve-channel PWM for four RGB LEDs with per-channel stepped fading toward
// target levels, paced by a prescaler counting PWM periods.
// ----------------------------------------------------------------------------
module rgb_pwm_with_smooth_fade
    import rgbpwm_pkg::*;
#(
    parameter int MAX_STEP = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic [1:0]              i_led_index,
    input  logic [1:0]              i_color_index,
    input  logic [LevelWidth-1:0]   i_target_level,
    input  logic signed [7:0]       i_step_size,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [NumChannels-1:0]  o_channel_on,
    output logic [LevelWidth-1:0]   o_pwm_position
);

    localparam logic [LevelWidth-1:0] MaxStepW = LevelWidth'(MAX_STEP);

    // configuration registers
    logic [LevelWidth-1:0] r_period;
    logic [LevelWidth-1:0] r_delay;

    // input register
    logic                  r_in_valid;
    t_command              r_command;
    logic [1:0]            r_led;
    logic [1:0]            r_color;
    logic [LevelWidth-1:0] r_tgt_in;
    logic [7:0]            r_step_in;

    // channel state
    logic [LevelWidth-1:0] r_cur  [NumChannels];
    logic [LevelWidth-1:0] r_tgt  [NumChannels];
    logic [LevelWidth-1:0] r_step [NumChannels];
    logic [LevelWidth-1:0] r_level;
    logic [LevelWidth-1:0] r_presc;
    logic                  r_pending;

    // output register
    logic                   r_out_valid;
    logic [NumChannels-1:0] r_channel_on;
    logic [LevelWidth-1:0]  r_pwm_position;

    logic                   advance;
    logic                   is_set;
    logic                   is_tick;
    logic [3:0]             sel_ch;
    logic [LevelWidth-1:0]  n_cur [NumChannels];
    logic [LevelWidth-1:0]  n_level;
    logic [LevelWidth-1:0]  n_presc;
    logic                   n_pending;
    logic [NumChannels-1:0] n_channel_on;
    logic [NumChannels-1:0] stepped;
    logic                   wrap;
    logic                   presc_run;
    logic                   fade_go;
    logic [LevelWidth-1:0]  level_inc;
    logic [LevelWidth-1:0]  presc_inc;
    logic [LevelWidth-1:0]  gap [NumChannels];
    logic [LevelWidth:0]    mag [NumChannels];

    // handshakes: a set never waits on the output side
    assign is_set      = r_in_valid && (r_command == CMD_SET);
    assign is_tick     = r_in_valid && (r_command == CMD_TICK);
    assign advance     = is_set || (is_tick && (!r_out_valid || i_out_ready));
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_out_valid;
    assign o_channel_on   = r_channel_on;
    assign o_pwm_position = r_pwm_position;

    // channel number led*3+color
    assign sel_ch = {r_led, 2'b00} - {2'b00, r_led} + {2'b00, r_color};

    // level counter and prescaler
    always_comb begin
        level_inc = r_level + 8'd1;
        presc_inc = r_presc + 8'd1;
        wrap      = level_inc >= r_period;
        n_level   = wrap ? '0 : level_inc;
        presc_run = wrap && r_pending && (r_delay != '0);
        fade_go   = presc_run && (presc_inc >= r_delay);
        if (fade_go) begin
            n_presc = '0;
        end else if (presc_run) begin
            n_presc = presc_inc;
        end else begin
            n_presc = r_presc;
        end
    end

    // fade step per channel and comparison against the new level
    always_comb begin
        for (int ch = 0; ch < NumChannels; ch++) begin
            gap[ch]     = r_cur[ch] - r_tgt[ch];
            mag[ch]     = gap[ch][LevelWidth-1] ? (9'd256 - {1'b0, gap[ch]})
                                                : {1'b0, gap[ch]};
            stepped[ch] = mag[ch] >= {1'b0, MaxStepW};
            n_cur[ch]   = r_cur[ch];
            if (fade_go) begin
                if (stepped[ch]) begin
                    n_cur[ch] = r_cur[ch] - r_step[ch];
                end else if (mag[ch] != '0) begin
                    n_cur[ch] = r_tgt[ch];
                end
            end
            if (r_delay == '0) begin
                n_channel_on[ch] = r_tgt[ch] > n_level;
            end else begin
                n_channel_on[ch] = n_cur[ch] > n_level;
            end
        end
    end

    // pending flag: set by a set word for a used color, re-evaluated at each fade step
    always_comb begin
        n_pending = r_pending;
        if (is_set && (r_color != COLOR_UNUSED)) begin
            n_pending = 1'b1;
        end else if (is_tick && fade_go) begin
            n_pending = |stepped;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PeriodReset;
            r_delay  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PWM_PERIOD: r_period <= i_cfg_data;
                REG_FADE_DELAY: r_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command <= t_command'(i_command);
            r_led     <= i_led_index;
            r_color   <= i_color_index;
            r_tgt_in  <= i_target_level;
            r_step_in <= i_step_size;
        end
    end

    // channel state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < NumChannels; ch++) begin
                r_cur[ch]  <= '0;
                r_tgt[ch]  <= '0;
                r_step[ch] <= '0;
            end
            r_level   <= '0;
            r_presc   <= '0;
            r_pending <= 1'b0;
        end else if (advance) begin
            r_pending <= n_pending;
            if (is_tick) begin
                for (int ch = 0; ch < NumChannels; ch++) begin
                    r_cur[ch] <= n_cur[ch];
                end
                r_level <= n_level;
                r_presc <= n_presc;
            end else if (r_color != COLOR_UNUSED) begin
                for (int ch = 0; ch < NumChannels; ch++) begin
                    if (sel_ch == 4'(ch)) begin
                        r_tgt[ch]  <= r_tgt_in;
                        r_step[ch] <= r_step_in;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_channel_on   <= n_channel_on;
            r_pwm_position <= n_level;
        end
    end

endmodule

@@ src/rgbpwm_checker.sv @@
// ----------------------------------------------------------------------------
// rgbpwm_checker
// Port-level checks of the LED PWM fader, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_pwm_with_smooth_fade_assert.svh"

module rgbpwm_checker
    import rgbpwm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_valid,
    input logic                    o_cfg_ready,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_command,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [NumChannels-1:0]  o_channel_on,
    input logic [LevelWidth-1:0]   o_pwm_position
);

    // a stalled output word holds
    `RPWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_channel_on) && $stable(o_pwm_position))

    // the input side stalls only behind a stalled output word
    `RPWM_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // an accepted tick word is followed by an output word showing
    `RPWM_ASSERT_D2(a_tick_result, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_command == CMD_TICK), o_out_valid)

    // configuration writes are always taken
    `RPWM_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind rgb_pwm_with_smooth_fade rgbpwm_checker u_rgbpwm_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the twelve-channel LED PWM fader. Plain tasks drive
// set and tick words and configuration writes; a process drives a randomly
// stalling output side. A small class mirrors the levels, the counters and the
// fade logic, and compares each output word against its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbpwm_pkg::*;

    localparam int FadeMaxStep  = 4;
    localparam int ResetCycles  = 6;
    localparam int SettleCycles = 6;
    localparam int HoldCycles   = 300;
    localparam int CycleLimit   = 200000;

    // one PWM frame as the block reports it
    typedef struct packed {
        logic [NumChannels-1:0] channel_on;
        logic [LevelWidth-1:0]  pwm_position;
    } t_pwm_frame;

    // Mirror of the fader: levels, counters, registers and frames still due
    class fader_model;
        bit [7:0]   period;
        bit [7:0]   delay;
        bit [7:0]   cur_level[NumChannels];
        bit [7:0]   tgt_level[NumChannels];
        bit [7:0]   fade_step[NumChannels];
        bit [7:0]   level_cnt;
        bit [7:0]   prescale;
        bit         fade_armed;
        t_pwm_frame frames_due[$];
        int         failures;

        function new();
            period     = PeriodReset;
            delay      = 8'd0;
            level_cnt  = 8'd0;
            prescale   = 8'd0;
            fade_armed = 1'b0;
            failures   = 0;
            foreach (cur_level[ch]) begin
                cur_level[ch] = 8'd0;
                tgt_level[ch] = 8'd0;
                fade_step[ch] = 8'd0;
            end
        endfunction

        function void take_reg(bit [CfgIdxWidth-1:0] idx, bit [7:0] data);
            if (idx == REG_PWM_PERIOD) begin
                period = data;
            end else if (idx == REG_FADE_DELAY) begin
                delay = data;
            end
        endfunction

        // accepted input word: update state, queue the frame a tick yields
        function void take_word(t_command cmd, bit [1:0] led, bit [1:0] color,
                                bit [7:0] target, bit [7:0] step);
            int         ch;
            bit [7:0]   gap;
            int         mag;
            t_pwm_frame frame;
            if (cmd == CMD_SET) begin
                // unused color: word is dropped
                if (color == COLOR_UNUSED) return;
                ch = led * NumColors + color;
                tgt_level[ch] = target;
                fade_step[ch] = step;
                fade_armed    = 1'b1;
                return;
            end
            level_cnt = level_cnt + 8'd1;
            if (level_cnt >= period) begin
                level_cnt = 8'd0;
                if (fade_armed && delay != 8'd0) begin
                    prescale = prescale + 8'd1;
                    if (prescale >= delay) begin
                        // prescaler expired: step or snap every channel
                        fade_armed = 1'b0;
                        for (ch = 0; ch < NumChannels; ch++) begin
                            gap = cur_level[ch] - tgt_level[ch];
                            mag = gap[7] ? 256 - int'(gap) : int'(gap);
                            if (mag >= FadeMaxStep) begin
                                cur_level[ch] = cur_level[ch] - fade_step[ch];
                                fade_armed    = 1'b1;
                            end else if (mag != 0) begin
                                cur_level[ch] = tgt_level[ch];
                            end
                        end
                        prescale = 8'd0;
                    end
                end
            end
            frame.pwm_position = level_cnt;
            for (ch = 0; ch < NumChannels; ch++) begin
                if (delay == 8'd0) frame.channel_on[ch] = tgt_level[ch] > level_cnt;
                else               frame.channel_on[ch] = cur_level[ch] > level_cnt;
            end
            frames_due.push_back(frame);
        endfunction

        // accepted output word against the oldest frame due
        function void match_frame(logic [NumChannels-1:0] on, logic [LevelWidth-1:0] pos);
            t_pwm_frame want;
            if (frames_due.size() == 0) begin
                $error("output word with no frame due: channel_on %03h, pwm_position %02h",
                       on, pos);
                failures++;
                return;
            end
            want = frames_due.pop_front();
            if (on !== want.channel_on) begin
                $error("channel_on: expected %03h, actual %03h", want.channel_on, on);
                failures++;
            end
            if (pos !== want.pwm_position) begin
                $error("pwm_position: expected %02h, actual %02h", want.pwm_position, pos);
                failures++;
            end
        endfunction
    endclass

    // DUT signals
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    logic [CfgIdxWidth-1:0]  i_cfg_index    = '0;
    logic [CfgDataWidth-1:0] i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic                    i_command      = 1'b0;
    logic [1:0]              i_led_index    = '0;
    logic [1:0]              i_color_index  = '0;
    logic [LevelWidth-1:0]   i_target_level = '0;
    logic signed [7:0]       i_step_size    = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic [NumChannels-1:0]  o_channel_on;
    logic [LevelWidth-1:0]   o_pwm_position;

    fader_model model = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;

    rgb_pwm_with_smooth_fade #(
        .MAX_STEP (FadeMaxStep)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_led_index    (i_led_index),
        .i_color_index  (i_color_index),
        .i_target_level (i_target_level),
        .i_step_size    (i_step_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_channel_on   (o_channel_on),
        .o_pwm_position (o_pwm_position)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HoldCycles - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            model.match_frame(o_channel_on, o_pwm_position);
        end
    end

    // one configuration write
    task automatic write_reg(bit [CfgIdxWidth-1:0] idx, bit [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model.take_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one input word; valid stays high on return
    task automatic send_word(t_command cmd, bit [1:0] led, bit [1:0] color,
                             bit [7:0] target, bit [7:0] step);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_led_index    = led;
        i_color_index  = color;
        i_target_level = target;
        i_step_size    = step;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model.take_word(cmd, led, color, target, step);
    endtask

    // random word: mostly ticks, sets mostly stepping toward their target
    task automatic send_random();
        bit [1:0] led;
        bit [1:0] color;
        bit [7:0] target;
        bit [7:0] step;
        bit [7:0] mag;
        int       ch;
        if ($urandom_range(99) < 72) begin
            send_word(CMD_TICK, 2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            led    = 2'($urandom);
            color  = ($urandom_range(15) == 0) ? COLOR_UNUSED : 2'($urandom_range(2));
            case ($urandom_range(9))
                0:       target = 8'h00;
                1:       target = 8'hFF;
                default: target = 8'($urandom);
            endcase
            if (color != COLOR_UNUSED && $urandom_range(9) < 7) begin
                ch   = led * NumColors + color;
                mag  = 8'($urandom_range(8, 1));
                step = (model.cur_level[ch] > target) ? mag : -mag;
            end else begin
                step = 8'($urandom);
            end
            send_word(CMD_SET, led, color, target, step);
        end
    endtask

    // let the block run dry before the next register write
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (model.frames_due.size() != 0 || hold_left != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic run_phase(bit [7:0] period, bit [7:0] delay, int unsigned send_pct,
                             int unsigned recv_pct, int count, bit hold);
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_FADE_DELAY, delay);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold) hold_req = 1'b1;
        repeat (count) send_random();
        settle();
    endtask

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at reset settings, no idling
        send_word(CMD_SET,  2'd0, 2'd0, 8'hFF, 8'h7F);
        send_word(CMD_SET,  2'd3, 2'd2, 8'h00, 8'h80);
        send_word(CMD_SET,  2'd3, COLOR_UNUSED, 8'hAA, 8'h55);
        send_word(CMD_SET,  2'd1, 2'd1, 8'h80, 8'h01);
        send_word(CMD_SET,  2'd2, 2'd2, 8'h01, 8'hFF);
        send_word(CMD_TICK, 2'd0, 2'd0, 8'h00, 8'h00);
        send_word(CMD_TICK, 2'd3, 2'd3, 8'hFF, 8'hFF);
        send_word(CMD_TICK, 2'd1, 2'd2, 8'h5A, 8'hA5);
        send_word(CMD_SET,  2'd2, 2'd0, 8'h03, 8'h00);
        send_word(CMD_SET,  2'd1, 2'd2, 8'h40, 8'hFC);
        send_word(CMD_TICK, 2'd0, 2'd0, 8'h00, 8'h00);
        send_word(CMD_TICK, 2'd0, 2'd0, 8'h00, 8'h00);
        send_word(CMD_SET,  2'd0, COLOR_UNUSED, 8'h00, 8'h00);
        send_word(CMD_TICK, 2'd0, 2'd0, 8'h00, 8'h00);
        send_word(CMD_TICK, 2'd0, 2'd0, 8'h00, 8'h00);
        settle();

        // unknown register, then fading with short periods
        write_reg(8'd2, 8'hAA);
        write_reg(8'hFF, 8'h55);
        run_phase(8'd4, 8'd1, 0, 0, 120, 1'b0);
        // shortest period, longest delay
        run_phase(8'd1, 8'd255, 47, 0, 80, 1'b0);
        // longest period, smoothing off
        run_phase(8'd255, 8'd0, 0, 47, 80, 1'b0);
        // long output hold-off while words keep coming
        run_phase(8'd8, 8'd2, 24, 24, 150, 1'b1);
        // zero period keeps the level at zero
        run_phase(8'd0, 8'd3, 0, 0, 30, 1'b0);
        run_phase(8'($urandom_range(16, 1)), 8'($urandom_range(4, 1)), 24, 24, 150, 1'b0);
        run_phase(8'd3, 8'd1, 0, 47, 100, 1'b0);

        if (model.failures == 0 && model.frames_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
